// ===== design/gcmb_pkg.sv =====
// ----------------------------------------------------------------------------
// gcmb_pkg
// Shared types, operation codes and helpers for the mark bitmap engine.
// ----------------------------------------------------------------------------
package gcmb_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int SLOT_W    = 12;

    typedef enum logic [2:0] {
        KIND_BARRIER = 3'd0,
        KIND_MARK    = 3'd1,
        KIND_BEGIN   = 3'd2,
        KIND_DRAIN   = 3'd3,
        KIND_SWEEP   = 3'd4,
        KIND_END     = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [SLOT_W-1:0]      slot;
        logic                   slot_live;
        logic                   major;
        logic [BIT_W-1:0]       sweep_word;
        logic [WORD_BITS-1:0]   live_word;
    } in_item_t;

    typedef struct packed {
        logic                   flag;
        logic [SLOT_W-1:0]      slot_out;
        logic                   valid_res;
        logic                   last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic step;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic sweep_go;
        logic sweep_last;
    } dp_status_t;

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== design/gc_mark_bitmap_barrier_sweep.sv =====
// ----------------------------------------------------------------------------
// gc_mark_bitmap_barrier_sweep
// Sticky mark bitmap, logged bitmap and remembered list for a GC slot heap.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one operation per transfer (barrier, try
//   mark, begin, drain, sweep word, end). m_valid/m_ready/m_data return the
//   results; the last bit closes the results of one operation.
// Sequencing:
//   One operation at a time. The accepting edge loads the item register, the
//   read state reads the bitmap and list RAMs, and the execute state loads
//   the output register once it is free; the next operation is accepted only
//   when the sequencer is back in idle. A sweep word with n garbage slots
//   loads nothing at execute and then one slot per cycle while the output
//   register is free, holding the block until its last slot is loaded.
//   The registered RAM read sets the read stage.
// Reset:
//   Marks, logged bits and list length clear at once through per-word valid
//   bits; no clearing pass. Major begin and minor end clear the same way.
// Stall:
//   A result waits in the output register while m_ready is low; the
//   sequencer holds in execute or sweep until the register frees.
// ----------------------------------------------------------------------------
module gc_mark_bitmap_barrier_sweep #(
    parameter int SLOTS = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gcmb_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gcmb_pkg::out_item_t   m_data
);

    gcmb_pkg::dp_cmd_t    cmd;
    gcmb_pkg::dp_status_t st;

    // sequencer: accept, read, execute, walk sweep bits
    gcmb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .st(st), .cmd(cmd)
    );

    // bitmaps, remembered list and result register
    gcmb_dp #(.SLOTS(SLOTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cmd(cmd), .st(st)
    );

endmodule

// ===== design/gcmb_ram.sv =====
// ----------------------------------------------------------------------------
// gcmb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gcmb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/gcmb_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcmb_ctrl
// Sequencer: accept, read bitmaps, execute, then walk sweep results.
// ----------------------------------------------------------------------------
module gcmb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gcmb_pkg::dp_status_t st,
    output gcmb_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (st.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = st.sweep_go ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (st.out_free) begin
                    cmd.step = 1'b1;
                    if (st.sweep_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.latch, cmd.exec, cmd.step}))
        else $error("more than one datapath command");
    a_exec_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> (state_reg == ST_IDLE || state_reg == ST_SWEEP))
        else $error("controller stuck in execute");
    a_latch_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.latch |=> (state_reg == ST_READ))
        else $error("accept not followed by read");

endmodule

// ===== design/gcmb_dp.sv =====
// ----------------------------------------------------------------------------
// gcmb_dp
// Datapath: item register, bitmap and list RAMs, counters, output register.
// ----------------------------------------------------------------------------
module gcmb_dp #(
    parameter int SLOTS = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gcmb_pkg::in_item_t     s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output gcmb_pkg::out_item_t    m_data,
    input  gcmb_pkg::dp_cmd_t      cmd,
    output gcmb_pkg::dp_status_t   st
);

    localparam int NWORDS = (SLOTS + gcmb_pkg::WORD_BITS - 1) / gcmb_pkg::WORD_BITS;
    localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int VW     = 1 << WAW;
    localparam int LAW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW     = $clog2(SLOTS + 1);

    gcmb_pkg::in_item_t  item_reg;
    gcmb_pkg::out_item_t out_reg;
    gcmb_pkg::out_item_t out_next;
    logic                out_valid_reg;
    logic                out_load;

    logic [VW-1:0]       mark_valid_reg;
    logic [VW-1:0]       logged_valid_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       drain_reg;
    logic [gcmb_pkg::WORD_BITS-1:0] garbage_reg;

    logic [15:0]         word_sel;
    logic [WAW-1:0]      word_addr;
    logic [gcmb_pkg::WORD_BITS-1:0] mark_q, logged_q, mark_word, logged_word, bit_sel;
    logic [gcmb_pkg::WORD_BITS-1:0] garbage_new, garbage_rest;
    logic [gcmb_pkg::SLOT_W-1:0]    list_q;
    logic                slot_ok, widx_ok, bar_hit, mark_hit;
    logic                mark_we, logged_we, list_we;
    logic [gcmb_pkg::BIT_W-1:0]     low_idx;

    // ---- address and masked read data
    always_comb begin
        if (item_reg.kind == gcmb_pkg::KIND_SWEEP) begin
            word_sel = 16'(item_reg.sweep_word);
        end else begin
            word_sel = 16'(item_reg.slot[gcmb_pkg::SLOT_W-1:gcmb_pkg::BIT_W]);
        end
    end
    assign word_addr   = word_sel[WAW-1:0];
    assign slot_ok     = (32'(item_reg.slot) < SLOTS);
    assign widx_ok     = (32'(item_reg.sweep_word) < NWORDS);
    assign mark_word   = mark_valid_reg[word_addr] ? mark_q : '0;
    assign logged_word = logged_valid_reg[word_addr] ? logged_q : '0;
    assign bit_sel     = gcmb_pkg::WORD_BITS'(1) << item_reg.slot[gcmb_pkg::BIT_W-1:0];
    assign bar_hit     = slot_ok && ((mark_word & bit_sel) != '0)
                         && ((logged_word & bit_sel) == '0);
    assign mark_hit    = slot_ok && item_reg.slot_live && ((mark_word & bit_sel) == '0);
    assign garbage_new = widx_ok ? (item_reg.live_word & ~mark_word) : '0;
    assign low_idx     = gcmb_pkg::lowest_set(garbage_reg);
    assign garbage_rest = garbage_reg & (garbage_reg - 1'b1);

    assign mark_we   = cmd.exec && (item_reg.kind == gcmb_pkg::KIND_MARK) && mark_hit;
    assign logged_we = cmd.exec && (item_reg.kind == gcmb_pkg::KIND_BARRIER) && bar_hit;
    assign list_we   = logged_we && (count_reg < CW'(SLOTS));

    gcmb_ram #(.WIDTH(gcmb_pkg::WORD_BITS), .DEPTH(NWORDS)) u_mark (
        .aclk(aclk), .we(mark_we), .waddr(word_addr), .wdata(mark_word | bit_sel),
        .raddr(word_addr), .rdata(mark_q)
    );
    gcmb_ram #(.WIDTH(gcmb_pkg::WORD_BITS), .DEPTH(NWORDS)) u_logged (
        .aclk(aclk), .we(logged_we), .waddr(word_addr), .wdata(logged_word | bit_sel),
        .raddr(word_addr), .rdata(logged_q)
    );
    gcmb_ram #(.WIDTH(gcmb_pkg::SLOT_W), .DEPTH(SLOTS)) u_list (
        .aclk(aclk), .we(list_we), .waddr(count_reg[LAW-1:0]), .wdata(item_reg.slot),
        .raddr(drain_reg[LAW-1:0]), .rdata(list_q)
    );

    // ---- result selection
    always_comb begin
        out_next      = '0;
        out_next.last = 1'b1;
        out_load      = 1'b0;
        if (cmd.step) begin
            out_load           = 1'b1;
            out_next.slot_out  = {item_reg.sweep_word, low_idx};
            out_next.valid_res = 1'b1;
            out_next.last      = (garbage_rest == '0);
        end else if (cmd.exec) begin
            out_load = !st.sweep_go;
            unique case (item_reg.kind)
                gcmb_pkg::KIND_BARRIER: out_next.flag = bar_hit;
                gcmb_pkg::KIND_MARK:    out_next.flag = mark_hit;
                gcmb_pkg::KIND_DRAIN: begin
                    if (drain_reg < count_reg) begin
                        out_next.slot_out  = list_q;
                        out_next.valid_res = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign st.out_free   = !out_valid_reg || m_ready;
    assign st.sweep_go   = (item_reg.kind == gcmb_pkg::KIND_SWEEP) && (garbage_new != '0);
    assign st.sweep_last = (garbage_rest == '0);

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ---- payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_reg <= s_data;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
        if (cmd.exec) begin
            garbage_reg <= garbage_new;
        end else if (cmd.step) begin
            garbage_reg <= garbage_rest;
        end
    end

    // ---- control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            mark_valid_reg   <= '0;
            logged_valid_reg <= '0;
            count_reg        <= '0;
            drain_reg        <= '0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (mark_we) begin
                mark_valid_reg[word_addr] <= 1'b1;
            end
            if (logged_we) begin
                logged_valid_reg[word_addr] <= 1'b1;
            end
            if (list_we) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.exec) begin
                priority case (1'b1)
                    item_reg.kind == gcmb_pkg::KIND_BEGIN && item_reg.major: begin
                        mark_valid_reg   <= '0;
                        logged_valid_reg <= '0;
                        count_reg        <= '0;
                        drain_reg        <= '0;
                    end
                    item_reg.kind == gcmb_pkg::KIND_END && !item_reg.major: begin
                        logged_valid_reg <= '0;
                        count_reg        <= '0;
                        drain_reg        <= '0;
                    end
                    item_reg.kind == gcmb_pkg::KIND_DRAIN && (drain_reg < count_reg): begin
                        drain_reg <= drain_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    a_drain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg <= count_reg)
        else $error("drain position passed list length");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(SLOTS))
        else $error("remembered list overflow");
    a_step_garbage: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (garbage_reg != '0))
        else $error("sweep step with no garbage left");
    a_major_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && item_reg.kind == gcmb_pkg::KIND_BEGIN && item_reg.major)
        |=> (count_reg == '0 && mark_valid_reg == '0))
        else $error("major collection did not clear state");

endmodule
